// ===== hdl/script_char_lexer_defines.svh =====
`ifndef SCRIPT_CHAR_LEXER_DEFINES_SVH
`define SCRIPT_CHAR_LEXER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SLX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lexer check failed");

// next-cycle implication, checked while out of reset
`define SLX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lexer check failed");

`endif

// ===== hdl/slx_pkg.sv =====
package slx_pkg;

	localparam int POS_BITS     = 16;
	localparam int OUT_POS_BITS = 16;
	localparam int WIDE_BITS    = POS_BITS + OUT_POS_BITS;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [OUT_POS_BITS-1:0] OUT_POS_MAX = {OUT_POS_BITS{1'b1}};

	localparam int OUT_DATA_BITS = 48;
	localparam int MAX_RESULTS   = 3;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [3:0] TAB_EXTRA_RESET    = 4'd3;
	localparam logic [7:0] COMMENT_CHAR_RESET = 8'd35;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;

	typedef enum logic [0:0] {
		REG_TAB_EXTRA    = 1'b0,
		REG_COMMENT_CHAR = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_END    = 2'd1,
		KIND_DELIM  = 2'd2,
		KIND_EOT    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       empty;
	} result_t;

	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RESULTS-1:0] res;
		logic [POS_BITS-1:0]       line;
		logic [POS_BITS-1:0]       col;
	} bundle_t;

	function automatic logic is_delim(input logic [7:0] c);
		return c inside {8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3B, 8'h3D, 8'h2C, 8'h3A};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SP, CH_TAB, CH_FF, CH_VT, CH_NL};
	endfunction

	function automatic logic [OUT_POS_BITS-1:0] clamp_pos(input logic [POS_BITS-1:0] v);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		if (w > WIDE_BITS'(OUT_POS_MAX))
			return OUT_POS_MAX;
		return w[OUT_POS_BITS-1:0];
	endfunction

endpackage

// ===== hdl/slx_front.sv =====
module slx_front import slx_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  reg_idx_t      cfg_addr,
	input  logic [7:0]    cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_char,
	input  logic          in_eot,
	input  logic          q_full,
	output logic          q_push,
	output bundle_t       q_bundle
);

	logic [3:0]          tab_extra_q;
	logic [7:0]          comment_char_q;
	logic                in_code_q, esc_q, in_comment_q, tok_open_q, seen_q;
	logic [POS_BITS-1:0] line_q, col_q;

	logic                in_code_d, esc_d, in_comment_d, tok_open_d, seen_d;
	logic [POS_BITS-1:0] line_d, col_d;
	logic [POS_BITS:0]   col_sum, line_sum;
	logic                tab_extra_on, is_nl, accept;
	logic [1:0]          n;
	result_t [MAX_RESULTS-1:0] res;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_nl    = (in_char == CH_NL);

	// tab widening only on the code path that treats the tab as whitespace
	assign tab_extra_on = !in_comment_q && in_code_q && (in_char != comment_char_q)
		&& (in_char == CH_TAB);

	always_comb begin
		col_sum  = {1'b0, col_q} + (POS_BITS+1)'(1)
			+ (tab_extra_on ? (POS_BITS+1)'(tab_extra_q) : '0);
		line_sum = {1'b0, line_q} + (POS_BITS+1)'(1);
		if (is_nl) begin
			col_d  = '0;
			line_d = line_sum[POS_BITS] ? POS_MAX : line_sum[POS_BITS-1:0];
		end else begin
			col_d  = (col_sum > {1'b0, POS_MAX}) ? POS_MAX : col_sum[POS_BITS-1:0];
			line_d = line_q;
		end
	end

	always_comb begin
		n            = '0;
		res          = '0;
		in_code_d    = in_code_q;
		esc_d        = esc_q;
		in_comment_d = in_comment_q;
		tok_open_d   = tok_open_q;
		seen_d       = seen_q;

		if (in_comment_q) begin
			if (is_nl)
				in_comment_d = 1'b0;
		end else if (in_code_q && in_char == comment_char_q) begin
			in_comment_d = 1'b1;
		end else if (in_code_q) begin
			if (is_space(in_char)) begin
				if (tok_open_d) begin
					res[n] = '{KIND_END, 8'h00, 1'b0};
					n = n + 2'd1;
					tok_open_d = 1'b0;
					seen_d = 1'b1;
				end
			end else if (is_delim(in_char)) begin
				if (tok_open_d) begin
					res[n] = '{KIND_END, 8'h00, 1'b0};
					n = n + 2'd1;
					tok_open_d = 1'b0;
				end
				res[n] = '{KIND_DELIM, in_char, 1'b0};
				n = n + 2'd1;
				seen_d = 1'b1;
			end else begin
				if (in_char == CH_QUOTE)
					in_code_d = 1'b0;
				res[n] = '{KIND_APPEND, in_char, 1'b0};
				n = n + 2'd1;
				tok_open_d = 1'b1;
			end
		end else begin
			if (esc_q) begin
				res[n] = '{KIND_APPEND, (in_char == CH_LOWER_N) ? CH_NL : in_char, 1'b0};
				n = n + 2'd1;
				tok_open_d = 1'b1;
				esc_d = 1'b0;
			end else if (in_char == CH_QUOTE) begin
				res[n] = '{KIND_APPEND, in_char, 1'b0};
				n = n + 2'd1;
				res[n] = '{KIND_END, 8'h00, 1'b0};
				n = n + 2'd1;
				tok_open_d = 1'b0;
				seen_d = 1'b1;
				in_code_d = 1'b1;
			end else if (in_char == CH_BSLASH) begin
				esc_d = 1'b1;
			end else begin
				res[n] = '{KIND_APPEND, in_char, 1'b0};
				n = n + 2'd1;
				tok_open_d = 1'b1;
			end
		end

		if (in_eot) begin
			if (tok_open_d) begin
				res[n] = '{KIND_END, 8'h00, 1'b0};
				n = n + 2'd1;
				seen_d = 1'b1;
			end
			res[n] = '{KIND_EOT, 8'h00, !seen_d};
			n = n + 2'd1;
		end
	end

	assign q_push        = accept && (n != 2'd0);
	assign q_bundle.cnt  = n;
	assign q_bundle.res  = res;
	assign q_bundle.line = line_d;
	assign q_bundle.col  = col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_extra_q    <= TAB_EXTRA_RESET;
			comment_char_q <= COMMENT_CHAR_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TAB_EXTRA:    tab_extra_q    <= cfg_wdata[3:0];
				REG_COMMENT_CHAR: comment_char_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_code_q    <= 1'b1;
			esc_q        <= 1'b0;
			in_comment_q <= 1'b0;
			tok_open_q   <= 1'b0;
			seen_q       <= 1'b0;
			line_q       <= POS_BITS'(1);
			col_q        <= '0;
		end else if (accept) begin
			if (in_eot) begin
				in_code_q    <= 1'b1;
				esc_q        <= 1'b0;
				in_comment_q <= 1'b0;
				tok_open_q   <= 1'b0;
				seen_q       <= 1'b0;
				line_q       <= POS_BITS'(1);
				col_q        <= '0;
			end else begin
				in_code_q    <= in_code_d;
				esc_q        <= esc_d;
				in_comment_q <= in_comment_d;
				tok_open_q   <= tok_open_d;
				seen_q       <= seen_d;
				line_q       <= line_d;
				col_q        <= col_d;
			end
		end
	end

endmodule

// ===== hdl/slx_queue.sv =====
module slx_queue import slx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_bundle,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output bundle_t head_bundle
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	bundle_t             mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push, do_pop;

	assign full        = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign head_valid  = (count_q != '0);
	assign head_bundle = mem_q[rd_q];
	assign do_push     = push && !full;
	assign do_pop      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_BITS'(1);
			if (do_pop)
				rd_q <= (rd_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_BITS'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_BITS'(1);
				2'b01:   count_q <= count_q - CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/slx_back.sv =====
module slx_back import slx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  bundle_t                  head_bundle,
	output logic                     pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]               m_tuser,
	output logic                     m_tlast
);

	logic [1:0] idx_q;
	result_t    cur;
	logic       is_last;

	assign cur      = head_bundle.res[idx_q];
	assign is_last  = (idx_q == head_bundle.cnt - 2'd1);
	assign m_tvalid = head_valid;
	assign m_tuser  = cur.kind;
	assign m_tlast  = is_last;
	assign m_tdata  = {7'b0, cur.empty, clamp_pos(head_bundle.col),
		clamp_pos(head_bundle.line), cur.ch};
	assign pop      = head_valid && m_tready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (head_valid && m_tready)
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
	end

endmodule

// ===== hdl/script_char_lexer.sv =====
// channel  dir  tdata                          tuser        tlast
// s_axis   in   char_in[7:0]                   -            end_of_text
// m_axis   out  char_out, line, column, empty  kind[1:0]    last
// cfg      in   cfg_addr 0 tab_extra_columns, 1 comment_char, write on cfg_we
//
// a byte is taken every cycle while the two-entry result queue has room
// each byte yields zero to three results, sent one a cycle from the queue head while m_tready is high
// sustained rate is one byte a cycle when results average at most one per byte
// arst_n resets all mode state and counters at once (line to 1), no clearing sweep
// a stalled output only stops input once the queue fills
module script_char_lexer import slx_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_addr,
	input  logic [7:0]               cfg_wdata,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // char_in
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // char_out, line, column, empty_script
	output logic [1:0]               m_tuser,   // kind
	output logic                     m_tlast
);

	logic    q_full, q_push, q_pop, q_valid;
	bundle_t push_bundle, head_bundle;

	slx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (reg_idx_t'(cfg_addr)),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.in_eot    (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_bundle  (push_bundle)
	);

	slx_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (q_push),
		.push_bundle (push_bundle),
		.full        (q_full),
		.pop         (q_pop),
		.head_valid  (q_valid),
		.head_bundle (head_bundle)
	);

	slx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head_bundle (head_bundle),
		.pop         (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== hdl/slx_checker.sv =====
`include "script_char_lexer_defines.svh"

module slx_checker import slx_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_DATA_BITS-1:0] m_tdata,
	input logic [1:0]               m_tuser,
	input logic                     m_tlast
);

	`SLX_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`SLX_ASSERT_NOW(a_eot_is_last, clk, arst_n, m_tvalid && m_tuser == KIND_EOT, m_tlast)
	`SLX_ASSERT_NOW(a_no_char, clk, arst_n, m_tvalid && (m_tuser == KIND_END || m_tuser == KIND_EOT), m_tdata[7:0] == 8'h00)
	`SLX_ASSERT_NOW(a_empty_only_eot, clk, arst_n, m_tvalid && m_tdata[40], m_tuser == KIND_EOT)
	`SLX_ASSERT_NOW(a_line_nonzero, clk, arst_n, m_tvalid, m_tdata[23:8] != 16'h0000)

endmodule

bind script_char_lexer slx_checker u_slx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
